/* hdl/ffca_pkg.sv */
// First-fit cell allocator package: field widths, request and status codes, FSM states.
// No dependencies.
package ffca_pkg;

  localparam int OWNER_ID_BITS = 8;
  localparam int SIZE_BITS     = 12;
  localparam int START_BITS    = 11;
  localparam int RUN_BITS      = 12;
  localparam int STATUS_BITS   = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_RESP
  } state_t;

endpackage

/* hdl/first_fit_cell_allocator_core.sv */
// First-fit cell allocator: owner store, one scan port and one write port, small sequencer.
// Depends on ffca_pkg.
// After reset the store is cleared one cell a cycle, no beat taken meanwhile.
// Allocate: a scan with one store read per cycle, then a fill of request_size cells,
// then a result. Free: scan and clear in one pass. Rejected requests (owner zero,
// bad size) skip the scan and go straight to the result.
// One request in flight at a time; a new beat may be taken while the last result waits.
module first_fit_cell_allocator_core
  import ffca_pkg::*;
#(
  parameter int CELL_COUNT = 2048,
  parameter int OWNER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // owner_id[7:0], request_size[19:8], zero pad
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // start_cell[10:0], run_length[22:11], zero pad
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int AW = $clog2(CELL_COUNT);
  localparam int CW = $clog2(CELL_COUNT + 1);

  state_t state, state_next;

  logic [OWNER_BITS-1:0] mem [CELL_COUNT];
  logic [OWNER_BITS-1:0] mem_q;

  logic                  op_free;
  logic [OWNER_BITS-1:0] id;
  logic [SIZE_BITS-1:0]  size;
  logic [CW-1:0]         rd_cnt;
  logic [CW-1:0]         chk_cnt;
  logic                  chk_vld;
  logic [CW-1:0]         run;
  logic                  in_run;
  logic [CW-1:0]         wr_cnt;
  logic [CW-1:0]         fill_left;

  status_t               res_status;
  logic [CW-1:0]         res_start;
  logic [CW-1:0]         res_len;

  logic [START_BITS-1:0] out_start;
  logic [RUN_BITS-1:0]   out_len;
  status_t               out_status;

  logic                  accept;
  logic [OWNER_BITS-1:0] req_id;
  logic [SIZE_BITS-1:0]  req_size;
  logic                  req_reject;
  logic                  cell_free;
  logic                  cell_hit;
  logic                  alloc_hit;
  logic                  free_hit;
  logic                  free_end;
  logic                  scan_end;
  logic                  conclude;
  logic                  rd_en;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [OWNER_BITS-1:0] wr_data;
  logic                  out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req_id        = OWNER_BITS'(s_axis_tdata[7:0]);
  assign req_size      = s_axis_tdata[19:8];
  assign req_reject    = (req_id == '0) ||
                         ((s_axis_tuser == OP_ALLOC) &&
                          ((req_size == '0) || (32'(req_size) > CELL_COUNT)));

  assign cell_free = (mem_q == '0);
  assign cell_hit  = (mem_q == id);
  assign alloc_hit = chk_vld && !op_free && cell_free && ((run + CW'(1)) == CW'(size));
  assign free_hit  = chk_vld && op_free && cell_hit;
  assign free_end  = chk_vld && op_free && !cell_hit && in_run;
  assign scan_end  = chk_vld && (chk_cnt == CW'(CELL_COUNT - 1));
  assign conclude  = alloc_hit || free_end || scan_end;
  assign out_load  = (state == S_RESP) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (wr_cnt == CW'(CELL_COUNT - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = req_reject ? S_RESP : S_SCAN;
      end
      S_SCAN: begin
        if (alloc_hit) state_next = S_FILL;
        else if (conclude) state_next = S_RESP;
      end
      S_FILL: if (fill_left == CW'(1)) state_next = S_RESP;
      S_RESP: if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = wr_cnt[AW-1:0];
    wr_data = '0;
    unique case (state)
      S_CLEAR: wr_en = 1'b1;
      S_SCAN: begin
        rd_en   = (rd_cnt != CW'(CELL_COUNT)) && !conclude;
        wr_en   = free_hit;
        wr_addr = chk_cnt[AW-1:0];
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_data = id;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      wr_cnt  <= '0;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= rd_en;
      if (state == S_CLEAR || state == S_FILL) wr_cnt <= wr_cnt + CW'(1);
      if (alloc_hit) wr_cnt <= CW'(chk_cnt + CW'(1) - CW'(size));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_free    <= s_axis_tuser;
      id         <= req_id;
      size       <= req_size;
      rd_cnt     <= '0;
      run        <= '0;
      in_run     <= 1'b0;
      res_start  <= '0;
      res_len    <= '0;
      res_status <= !req_reject ? ST_DONE :
                    (s_axis_tuser == OP_FREE) ? ST_NOT_FOUND : ST_NO_SPACE;
    end
    if (rd_en) begin
      rd_cnt  <= rd_cnt + CW'(1);
      chk_cnt <= rd_cnt;
    end
    if (state == S_SCAN && chk_vld) begin
      if (op_free) begin
        if (free_hit) begin
          in_run  <= 1'b1;
          res_len <= res_len + CW'(1);
          if (!in_run) res_start <= chk_cnt;
        end
        if (scan_end && !in_run && !free_hit) res_status <= ST_NOT_FOUND;
      end else begin
        run <= cell_free ? run + CW'(1) : '0;
        if (alloc_hit) begin
          res_start <= CW'(chk_cnt + CW'(1) - CW'(size));
          res_len   <= CW'(size);
          fill_left <= CW'(size);
        end else if (scan_end) begin
          res_status <= ST_NO_SPACE;
        end
      end
    end
    if (state == S_FILL) fill_left <= fill_left - CW'(1);
    if (out_load) begin
      out_status <= res_status;
      out_start  <= START_BITS'(res_start);
      out_len    <= RUN_BITS'(res_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {1'b0, out_len, out_start};
  assign m_axis_tuser = out_status;

endmodule
